// ===== rtl/tws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants and controller/datapath interface types for the trie
// word insert/search unit.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int TWS_NODE_COUNT    = 4096;
    localparam int TWS_ALPHABET_SIZE = 26;
    localparam int TWS_LETTER_W      = 5;

    localparam logic TWS_FUNC_INSERT = 1'b0;
    localparam logic TWS_FUNC_SEARCH = 1'b1;

    localparam logic TWS_STATUS_OK   = 1'b0;
    localparam logic TWS_STATUS_FULL = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take_item;    // latch the input word, issue the link read
        logic do_lookup;    // link read data valid: follow or allocate
        logic do_close;     // close the word at the cursor node
        logic take_mark;    // end-mark read data valid
        logic push_result;  // load the output register, reset the walk
    } tws_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_busy;       // memories still being swept after reset
        logic walk;             // input word takes a step down the trie
        logic in_close;         // input word closes the current word
        logic item_close;       // latched word closes the current word
        logic close_search_ok;  // search close that needs the end mark
        logic out_free;         // output register can take a result
    } tws_status_t;

endpackage

// ===== rtl/tws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer for the trie unit: takes one word at a time, steps it through
// link lookup, word close, end-mark read and result hand-off.
// ----------------------------------------------------------------------------
module tws_ctrl
    import tws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tws_status_t st,
    output tws_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_CLOSE  = 5'b00100,
        ST_MARK   = 5'b01000,
        ST_PUSH   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign s_tready = (state_reg == ST_IDLE) && !st.clear_busy;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (st.walk) begin
                        state_next = ST_LOOKUP;
                    end else if (st.in_close) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_LOOKUP: begin
                state_next = st.item_close ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE: begin
                state_next = st.close_search_ok ? ST_MARK : ST_PUSH;
            end
            ST_MARK: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd.take_item   = take;
        cmd.do_lookup   = (state_reg == ST_LOOKUP);
        cmd.do_close    = (state_reg == ST_CLOSE);
        cmd.take_mark   = (state_reg == ST_MARK);
        cmd.push_result = (state_reg == ST_PUSH) && st.out_free;
    end

endmodule

// ===== rtl/tws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_datapath
// Trie storage and walk state: child-link and end-mark memories, cursor,
// free-node pointer, failure flags, reset sweep and the output register.
// ----------------------------------------------------------------------------
module tws_datapath
    import tws_pkg::*;
#(
    parameter int NODE_COUNT    = TWS_NODE_COUNT,
    parameter int ALPHABET_SIZE = TWS_ALPHABET_SIZE
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_func,
    input  logic                    in_letter_valid,
    input  logic [TWS_LETTER_W-1:0] in_letter,
    input  logic                    in_word_end,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic                    out_found,
    output logic                    out_status,
    input  tws_cmd_t                cmd,
    output tws_status_t             st
);

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int TOTAL = NODE_COUNT * ALPHABET_SIZE;
    localparam int SW    = $clog2(TOTAL);
    localparam int LCW   = 7;

    logic [NW-1:0] cursor_reg;
    logic [NW:0]   free_reg;
    logic          broken_reg;
    logic          failed_reg;
    logic          func_reg;
    logic          close_reg;
    logic [SW-1:0] slot_reg;
    logic [SW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;
    logic          found_reg;
    logic          status_reg;
    logic          out_valid_reg;
    logic          out_found_reg;
    logic          out_status_reg;

    logic          in_range;
    logic [SW-1:0] slot_in;
    logic [NW-1:0] child_rdata;
    logic          child_missing;
    logic          alloc_ok;
    logic          alloc;
    logic          child_we;
    logic [SW-1:0] child_waddr;
    logic [NW-1:0] child_wdata;
    logic          clr_end;
    logic          mark_set;
    logic          end_we;
    logic [NW-1:0] end_waddr;
    logic          end_wdata;
    logic          end_rdata;
    logic          walk_ok;

    assign in_range      = LCW'(in_letter) < LCW'(ALPHABET_SIZE);
    assign slot_in       = SW'(cursor_reg) * SW'(ALPHABET_SIZE) + SW'(in_letter);
    assign walk_ok       = !broken_reg && !failed_reg;
    assign child_missing = (child_rdata == '0);
    assign alloc_ok      = free_reg < (NW+1)'(NODE_COUNT);
    assign alloc         = cmd.do_lookup && child_missing
                           && (func_reg == TWS_FUNC_INSERT) && alloc_ok;

    // the reset sweep owns both write ports until it finishes
    assign child_we    = clr_busy_reg || alloc;
    assign child_waddr = clr_busy_reg ? clr_cnt_reg : slot_reg;
    assign child_wdata = clr_busy_reg ? '0 : free_reg[NW-1:0];

    assign clr_end   = clr_busy_reg && (clr_cnt_reg < SW'(NODE_COUNT));
    assign mark_set  = cmd.do_close && (func_reg == TWS_FUNC_INSERT) && walk_ok;
    assign end_we    = clr_end || mark_set;
    assign end_waddr = clr_busy_reg ? clr_cnt_reg[NW-1:0] : cursor_reg;
    assign end_wdata = !clr_busy_reg;

    tws_ram #(
        .WIDTH (NW),
        .DEPTH (TOTAL)
    ) u_child_ram (
        .aclk  (aclk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (slot_in),
        .rdata (child_rdata)
    );

    tws_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_end_ram (
        .aclk  (aclk),
        .we    (end_we),
        .waddr (end_waddr),
        .wdata (end_wdata),
        .raddr (cursor_reg),
        .rdata (end_rdata)
    );

    // reset sweep over the link memory; end marks ride along
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == SW'(TOTAL - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            func_reg  <= in_func;
            close_reg <= in_word_end;
            slot_reg  <= slot_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            free_reg   <= (NW+1)'(1);
            broken_reg <= 1'b0;
            failed_reg <= 1'b0;
        end else if (cmd.push_result) begin
            cursor_reg <= '0;
            broken_reg <= 1'b0;
            failed_reg <= 1'b0;
        end else if (cmd.do_lookup) begin
            if (!child_missing) begin
                cursor_reg <= child_rdata;
            end else if (func_reg == TWS_FUNC_SEARCH) begin
                broken_reg <= 1'b1;
            end else if (!alloc_ok) begin
                failed_reg <= 1'b1;
            end else begin
                cursor_reg <= free_reg[NW-1:0];
                free_reg   <= free_reg + (NW+1)'(1);
            end
        end
    end

    // result of the closing word
    always_ff @(posedge aclk) begin
        if (cmd.do_close) begin
            found_reg  <= 1'b0;
            status_reg <= ((func_reg == TWS_FUNC_INSERT) && !walk_ok)
                          ? TWS_STATUS_FULL : TWS_STATUS_OK;
        end else if (cmd.take_mark) begin
            found_reg  <= end_rdata;
            status_reg <= TWS_STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_result) begin
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_status = out_status_reg;

    always_comb begin
        st.clear_busy      = clr_busy_reg;
        st.walk            = in_letter_valid && in_range && walk_ok;
        st.in_close        = in_word_end;
        st.item_close      = close_reg;
        st.close_search_ok = (func_reg == TWS_FUNC_SEARCH) && walk_ok;
        st.out_free        = !out_valid_reg || m_tready;
    end

endmodule

// ===== rtl/trie_word_insert_search_unit.sv =====
`timescale 1ns / 1ps
// Flow: one word at a time; s_tready stays low until the last word is done. A walked letter
//   adds a link read (optional new-link write); a closing word adds the close and result hand-off.
// Result: m_tvalid is registered from the push state, reached from the lookup of a walked letter,
//   the close, and the end-mark read of a search that reaches its node; m_tready stalls hold push.
// Reset: memories swept clear after aresetn, one link entry a cycle, NODE_COUNT*ALPHABET_SIZE
//   entries (106496 by default); s_tready stays low until the sweep ends.
// ----------------------------------------------------------------------------
// trie_word_insert_search_unit
// Dictionary trie with word insert and search, one letter per stream word.
// ----------------------------------------------------------------------------
module trie_word_insert_search_unit
    import tws_pkg::*;
#(
    parameter int NODE_COUNT    = TWS_NODE_COUNT,
    parameter int ALPHABET_SIZE = TWS_ALPHABET_SIZE
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [1:0] s_tuser,   // [0] func, [1] letter_valid
    input  logic       s_tlast,   // word_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] found, [7:1] zero
    output logic       m_tuser    // [0] status
);

    tws_cmd_t    cmd;
    tws_status_t st;
    logic        found;
    logic        status;

    tws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tws_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_func         (s_tuser[0]),
        .in_letter_valid (s_tuser[1]),
        .in_letter       (s_tdata[TWS_LETTER_W-1:0]),
        .in_word_end     (s_tlast),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_found       (found),
        .out_status      (status),
        .cmd             (cmd),
        .st              (st)
    );

    assign m_tdata = {7'b0, found};
    assign m_tuser = status;

endmodule

// ===== rtl/tws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks for the trie unit, bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reset starts the memory sweep, so no word is taken
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during memory sweep");

    // found comes only from a search, a failure only from an insert
    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tuser))
        else $error("found and failure status both set");

endmodule

bind trie_word_insert_search_unit tws_checker u_tws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
